>>> design/pewq_pkg.sv
// Shared types and codes for the priority event wait queue.
`timescale 1ns / 1ps
`default_nettype none
package pewq_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] FUNC_TAKE    = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_WAIT    = 2'd2;
    localparam logic [1:0] FUNC_SIGNAL  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NOT_OWNER = 2'd1;
    localparam logic [1:0] ERR_FULL      = 2'd2;

    // fixed field widths
    localparam int THREAD_W   = 5;
    localparam int PRIO_FLD_W = 8;
    localparam int MASK_W     = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // per-cell move control
    typedef struct packed {
        logic load_new;    // take the incoming request
        logic from_left;   // take the entry of the cell before
        logic from_right;  // take the entry of the cell after
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> design/pewq_cell.sv
// One slot of the sorted wait queue: holds a thread id and its priority.
`timescale 1ns / 1ps
`default_nettype none
module pewq_cell #(
    parameter int PRIO_W = 8
) (
    input  wire                             i_clk,
    input  pewq_pkg::t_cell_ctrl            i_ctrl,
    input  wire [pewq_pkg::THREAD_W-1:0]    i_new_thread,
    input  wire [PRIO_W-1:0]                i_new_prio,
    input  wire [pewq_pkg::THREAD_W-1:0]    i_left_thread,
    input  wire [PRIO_W-1:0]                i_left_prio,
    input  wire [pewq_pkg::THREAD_W-1:0]    i_right_thread,
    input  wire [PRIO_W-1:0]                i_right_prio,
    output logic [pewq_pkg::THREAD_W-1:0]   o_thread,
    output logic [PRIO_W-1:0]               o_prio,
    output logic                            o_lower   // stored prio below incoming
);

    logic [pewq_pkg::THREAD_W-1:0] r_thread, n_thread;
    logic [PRIO_W-1:0]             r_prio, n_prio;

    always_comb begin
        n_thread = r_thread;
        n_prio   = r_prio;
        if (i_ctrl.load_new) begin
            n_thread = i_new_thread;
            n_prio   = i_new_prio;
        end else if (i_ctrl.from_left) begin
            n_thread = i_left_thread;
            n_prio   = i_left_prio;
        end else if (i_ctrl.from_right) begin
            n_thread = i_right_thread;
            n_prio   = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thread <= n_thread;
        r_prio   <= n_prio;
    end

    assign o_thread = r_thread;
    assign o_prio   = r_prio;
    assign o_lower  = (r_prio < i_new_prio);

endmodule
`default_nettype wire

>>> design/priority_event_wait_queue_unit.sv
// Top level of the priority event wait queue: owner register, cell chain, control.
//
// Channel   Dir  Signals                         Contents
// s (in)    in   i_s_tvalid/o_s_tready           tuser: func; tdata: thread_id, priority_req
// m (out)   out  o_m_tvalid/i_m_tready           tdata: granted .. error_code
//
// take, release and wait finish at the accepting edge, which also registers their result.
// signal drains the chain through the head cell, one entry per cycle.
// Sorted insert: every cell compares its priority with the request in parallel and the
// chain shifts right by one from the insert point; release shifts the chain left.
// Reset (synchronous, active low) empties the queue and frees the event; cell contents
// are not reset. A new request is taken while a result waits only if it can be handed off.
`timescale 1ns / 1ps
`default_nettype none
module priority_event_wait_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int THREAD_COUNT  = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [4:0] thread_id, [12:5] priority_req, [15:13] zero
    input  wire  [pewq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [0] granted, [1] blocked, [33:2] woken_mask, [34] owner_valid,
    // [39:35] owner_id, [41:40] error_code, [47:42] zero
    output logic [pewq_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TW    = pewq_pkg::THREAD_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // control state
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_held, n_held;
    logic [TW-1:0]    r_owner, n_owner;
    logic             r_out_valid, n_out_valid;
    // payload
    logic [pewq_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [pewq_pkg::MASK_W-1:0]     r_acc, n_acc;

    // request fields
    logic [1:0]               w_func;
    logic [TW-1:0]            w_id;
    logic [15:0]              w_prio_ext;
    logic [PRIORITY_BITS-1:0] w_prio;

    assign w_func     = i_s_tuser;
    assign w_id       = i_s_tdata[TW-1:0];
    assign w_prio_ext = {8'b0, i_s_tdata[TW +: pewq_pkg::PRIO_FLD_W]};
    assign w_prio     = w_prio_ext[PRIORITY_BITS-1:0];

    // cell chain
    logic [TW-1:0]            w_thread [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_cprio  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   w_lower;
    logic [QUEUE_DEPTH-1:0]   w_lt;      // insert point at or before this cell
    pewq_pkg::t_cell_ctrl     w_ctrl [QUEUE_DEPTH];

    logic w_out_free, w_accept, w_full, w_insert, w_pop, w_is_owner;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_is_owner = r_held && (r_owner == w_id);

    assign w_insert = w_accept && !w_full &&
                      ((w_func == pewq_pkg::FUNC_TAKE && r_held) ||
                       w_func == pewq_pkg::FUNC_WAIT);
    assign w_pop    = (w_accept && w_func == pewq_pkg::FUNC_RELEASE && w_is_owner &&
                       r_count != '0) ||
                      (r_state == ST_DRAIN && r_count != '0);

    function automatic logic [pewq_pkg::MASK_W-1:0] wake_bit(input logic [TW-1:0] id);
        logic [pewq_pkg::MASK_W-1:0] bits;
        bits = '0;
        if (32'(id) < THREAD_COUNT)
            bits = pewq_pkg::MASK_W'(1) << id;
        return bits;
    endfunction

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic w_prev;
            // entries past the fill count never hold back the insert point
            assign w_lt[g] = (CNT_W'(g) >= r_count) || w_lower[g];
            if (g == 0) begin : g_first
                assign w_prev = 1'b0;
            end else begin : g_rest
                assign w_prev = w_lt[g-1];
            end
            assign w_ctrl[g].load_new   = w_insert && w_lt[g] && !w_prev;
            assign w_ctrl[g].from_left  = w_insert && w_prev;
            assign w_ctrl[g].from_right = w_pop;

            pewq_cell #(
                .PRIO_W (PRIORITY_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl[g]),
                .i_new_thread   (w_id),
                .i_new_prio     (w_prio),
                .i_left_thread  (w_thread[(g == 0) ? 0 : g-1]),
                .i_left_prio    (w_cprio[(g == 0) ? 0 : g-1]),
                .i_right_thread (w_thread[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .i_right_prio   (w_cprio[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .o_thread       (w_thread[g]),
                .o_prio         (w_cprio[g]),
                .o_lower        (w_lower[g])
            );
        end
    endgenerate

    // result packing
    function automatic logic [pewq_pkg::OUT_DATA_W-1:0] pack_out(
        input logic                        granted,
        input logic                        blocked,
        input logic [pewq_pkg::MASK_W-1:0] woken,
        input logic                        held,
        input logic [TW-1:0]               owner,
        input logic [1:0]                  err
    );
        return {6'b0, err, (held ? owner : {TW{1'b0}}), held, woken, blocked, granted};
    endfunction

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_held      = r_held;
        n_owner     = r_owner;
        n_acc       = r_acc;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_tready;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_func)
                        pewq_pkg::FUNC_TAKE: begin
                            if (!r_held) begin
                                n_held     = 1'b1;
                                n_owner    = w_id;
                                n_out_data = pack_out(1'b1, 1'b0, '0, 1'b1, w_id,
                                                      pewq_pkg::ERR_NONE);
                            end else if (!w_full) begin
                                n_count    = r_count + CNT_W'(1);
                                n_out_data = pack_out(1'b0, 1'b1, '0, r_held, r_owner,
                                                      pewq_pkg::ERR_NONE);
                            end else begin
                                n_out_data = pack_out(1'b0, 1'b0, '0, r_held, r_owner,
                                                      pewq_pkg::ERR_FULL);
                            end
                            n_out_valid = 1'b1;
                        end
                        pewq_pkg::FUNC_RELEASE: begin
                            if (!w_is_owner) begin
                                n_out_data = pack_out(1'b0, 1'b0, '0, r_held, r_owner,
                                                      pewq_pkg::ERR_NOT_OWNER);
                            end else if (r_count != '0) begin
                                // hand off to the head waiter
                                n_count    = r_count - CNT_W'(1);
                                n_owner    = w_thread[0];
                                n_out_data = pack_out(1'b0, 1'b0, wake_bit(w_thread[0]),
                                                      1'b1, w_thread[0], pewq_pkg::ERR_NONE);
                            end else begin
                                n_held     = 1'b0;
                                n_out_data = pack_out(1'b0, 1'b0, '0, 1'b0, r_owner,
                                                      pewq_pkg::ERR_NONE);
                            end
                            n_out_valid = 1'b1;
                        end
                        pewq_pkg::FUNC_WAIT: begin
                            if (!w_full) begin
                                n_count    = r_count + CNT_W'(1);
                                n_out_data = pack_out(1'b0, 1'b1, '0, r_held, r_owner,
                                                      pewq_pkg::ERR_NONE);
                            end else begin
                                n_out_data = pack_out(1'b0, 1'b0, '0, r_held, r_owner,
                                                      pewq_pkg::ERR_FULL);
                            end
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            // signal: drain the chain through the head cell
                            n_acc   = '0;
                            n_state = ST_DRAIN;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (r_count != '0) begin
                    n_acc   = r_acc | wake_bit(w_thread[0]);
                    n_count = r_count - CNT_W'(1);
                end else if (w_out_free) begin
                    n_out_data  = pack_out(1'b0, 1'b0, r_acc, r_held, r_owner,
                                           pewq_pkg::ERR_NONE);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_held      <= n_held;
            r_owner     <= n_owner;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

>>> verif/priority_event_wait_queue_unit_tb.sv
// Self-checking testbench for the priority event wait queue unit.
`timescale 1ns / 1ps
module priority_event_wait_queue_unit_tb;

    localparam int WAIT_SLOTS = 16;

    // Result layout from the lowest bit up:
    // granted, blocked, woken_mask, owner_valid, owner_id, error_code
    typedef struct packed {
        logic [1:0]  error_code;
        logic [4:0]  owner_id;
        logic        owner_valid;
        logic [31:0] woken_mask;
        logic        blocked;
        logic        granted;
    } t_event_result;

    // One row of the directed table. A row with reps > 1 stands for a run of
    // requests with rising thread ids and priorities cycling through 0/64/128/192
    // above the base value. When typed is set, want is the result to check.
    typedef struct {
        logic [1:0]    op;
        logic [4:0]    tid;
        logic [7:0]    pri;
        int            reps;
        bit            typed;
        t_event_result want;
    } t_stim_row;

    localparam t_event_result UNTYPED = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;     // [4:0] thread_id, [12:5] priority_req, [15:13] zero
    logic [1:0]  i_s_tuser = '0;     // [1:0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;          // [0] granted, [1] blocked, [33:2] woken_mask,
                                     // [34] owner_valid, [39:35] owner_id,
                                     // [41:40] error_code, [47:42] zero

    // Mirror of the event object
    logic [4:0] waiter_tid [WAIT_SLOTS];
    logic [7:0] waiter_pri [WAIT_SLOTS];
    int         waiter_count = 0;
    logic [4:0] owner_tid = '0;
    bit         owner_held = 1'b0;

    t_event_result results_due [$];
    int            mismatches = 0;
    bit            quiet = 1'b0;     // no gaps on either side while set

    t_stim_row directed_rows [14] = '{
        // release of a free event right after reset
        '{pewq_pkg::FUNC_RELEASE, 5'd0,  8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_NOT_OWNER, 5'd0, 1'b0, 32'h0, 1'b0, 1'b0}},
        // signal with nobody waiting
        '{pewq_pkg::FUNC_SIGNAL,  5'd0,  8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_NONE, 5'd0, 1'b0, 32'h0, 1'b0, 1'b0}},
        // free event: granted at once
        '{pewq_pkg::FUNC_TAKE,    5'd31, 8'd255, 1, 1'b1,
          '{pewq_pkg::ERR_NONE, 5'd31, 1'b1, 32'h0, 1'b0, 1'b1}},
        // release by a thread that does not own it
        '{pewq_pkg::FUNC_RELEASE, 5'd0,  8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_NOT_OWNER, 5'd31, 1'b1, 32'h0, 1'b0, 1'b0}},
        // owner takes again: queued like anyone else
        '{pewq_pkg::FUNC_TAKE,    5'd31, 8'd0,   1, 1'b0, UNTYPED},
        // fill with waits, ties at every priority level
        '{pewq_pkg::FUNC_WAIT,    5'd1,  8'd0,  14, 1'b0, UNTYPED},
        // highest priority take jumps to the head, queue now full
        '{pewq_pkg::FUNC_TAKE,    5'd0,  8'd255, 1, 1'b0, UNTYPED},
        // full queue refuses both wait and take
        '{pewq_pkg::FUNC_WAIT,    5'd21, 8'd255, 1, 1'b1,
          '{pewq_pkg::ERR_FULL, 5'd31, 1'b1, 32'h0, 1'b0, 1'b0}},
        '{pewq_pkg::FUNC_TAKE,    5'd22, 8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_FULL, 5'd31, 1'b1, 32'h0, 1'b0, 1'b0}},
        // hand-off to the head waiter (queued by take)
        '{pewq_pkg::FUNC_RELEASE, 5'd31, 8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_NONE, 5'd0, 1'b1, 32'h1, 1'b0, 1'b0}},
        // hand-off to a waiter queued by wait
        '{pewq_pkg::FUNC_RELEASE, 5'd0,  8'd0,   1, 1'b0, UNTYPED},
        // signal on a nearly full queue
        '{pewq_pkg::FUNC_SIGNAL,  5'd9,  8'd99,  1, 1'b0, UNTYPED},
        // owner releases with nobody waiting: event freed
        '{pewq_pkg::FUNC_RELEASE, 5'd4,  8'd0,   1, 1'b0, UNTYPED},
        '{pewq_pkg::FUNC_RELEASE, 5'd4,  8'd0,   1, 1'b1,
          '{pewq_pkg::ERR_NOT_OWNER, 5'd0, 1'b0, 32'h0, 1'b0, 1'b0}}
    };

    priority_event_wait_queue_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sorted insert behind every entry of equal or higher priority.
    function automatic bit waiter_insert(input logic [4:0] tid, input logic [7:0] pri);
        int pos;
        if (waiter_count >= WAIT_SLOTS) return 1'b0;
        pos = 0;
        while (pos < waiter_count && waiter_pri[pos] >= pri) pos++;
        for (int k = waiter_count; k > pos; k--) begin
            waiter_tid[k] = waiter_tid[k - 1];
            waiter_pri[k] = waiter_pri[k - 1];
        end
        waiter_tid[pos] = tid;
        waiter_pri[pos] = pri;
        waiter_count++;
        return 1'b1;
    endfunction

    function automatic t_event_result predict_event_result(input logic [1:0] op,
                                                           input logic [4:0] tid,
                                                           input logic [7:0] pri);
        t_event_result res;
        res = '0;
        case (op)
            pewq_pkg::FUNC_TAKE: begin
                if (!owner_held) begin
                    owner_held  = 1'b1;
                    owner_tid   = tid;
                    res.granted = 1'b1;
                end else if (waiter_insert(tid, pri)) begin
                    res.blocked = 1'b1;
                end else begin
                    res.error_code = pewq_pkg::ERR_FULL;
                end
            end
            pewq_pkg::FUNC_RELEASE: begin
                if (owner_held && owner_tid == tid) begin
                    if (waiter_count > 0) begin
                        owner_tid      = waiter_tid[0];
                        res.woken_mask = 32'h1 << waiter_tid[0];
                        for (int k = 1; k < waiter_count; k++) begin
                            waiter_tid[k - 1] = waiter_tid[k];
                            waiter_pri[k - 1] = waiter_pri[k];
                        end
                        waiter_count--;
                    end else begin
                        owner_held = 1'b0;
                    end
                end else begin
                    res.error_code = pewq_pkg::ERR_NOT_OWNER;
                end
            end
            pewq_pkg::FUNC_WAIT: begin
                if (waiter_insert(tid, pri)) res.blocked = 1'b1;
                else res.error_code = pewq_pkg::ERR_FULL;
            end
            default: begin
                for (int k = 0; k < waiter_count; k++) res.woken_mask |= 32'h1 << waiter_tid[k];
                waiter_count = 0;
            end
        endcase
        res.owner_valid = owner_held;
        res.owner_id    = owner_held ? owner_tid : 5'd0;
        return res;
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge that accepted the request.
    task automatic send_request(input logic [1:0] op, input logic [4:0] tid,
                                input logic [7:0] pri, input bit typed,
                                input t_event_result typed_want);
        int gap;
        t_event_result predicted;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, pri, tid};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = predict_event_result(op, tid, pri);
        results_due.push_back(typed ? typed_want : predicted);
    endtask

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver stalls
    initial begin
        int stall;
        int run;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : pick_gap();
            run   = $urandom_range(1, 6);
            repeat (stall) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end
            repeat (run) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_event_result got;
        t_event_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[41:0];
            if (results_due.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t ns: result %h with no request pending", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                flag_field("granted",     32'(want.granted),     32'(got.granted));
                flag_field("blocked",     32'(want.blocked),     32'(got.blocked));
                flag_field("woken_mask",  want.woken_mask,       got.woken_mask);
                flag_field("owner_valid", 32'(want.owner_valid), 32'(got.owner_valid));
                flag_field("owner_id",    32'(want.owner_id),    32'(got.owner_id));
                flag_field("error_code",  32'(want.error_code),  32'(got.error_code));
                flag_field("pad bits",    32'd0,                 32'(o_m_tdata[47:42]));
            end
        end
    end

    // Stimulus
    initial begin
        int sig_pct [8];
        int prio_hi [8];
        int r;
        logic [1:0] op;
        logic [4:0] tid;
        logic [7:0] pri;

        sig_pct = '{5, 1, 12, 2, 25, 3, 8, 1};
        prio_hi = '{3, 255, 15, 255, 3, 255, 1, 255};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                send_request(directed_rows[i].op, directed_rows[i].tid + 5'(k),
                             directed_rows[i].pri + 8'((k % 4) * 64),
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases: the signal rate sets how often the queue runs full,
        // the priority range sets how many ties there are.
        for (int ph = 0; ph < 8; ph++) begin
            quiet = (ph == 2 || ph == 5);
            for (int n = 0; n < 250; n++) begin
                tid = 5'($urandom_range(0, 31));
                r = $urandom_range(0, 19);
                if (r == 0) pri = 8'd0;
                else if (r == 1) pri = 8'hFF;
                else pri = 8'($urandom_range(0, prio_hi[ph]));
                r = $urandom_range(0, 99);
                if (r < sig_pct[ph]) begin
                    op = pewq_pkg::FUNC_SIGNAL;
                end else if (r < sig_pct[ph] + 30) begin
                    op = pewq_pkg::FUNC_TAKE;
                end else if (r < sig_pct[ph] + 55) begin
                    op = pewq_pkg::FUNC_RELEASE;
                    // mostly proper releases by the owner, some stray ones
                    if (owner_held && $urandom_range(0, 9) < 8) tid = owner_tid;
                end else begin
                    op = pewq_pkg::FUNC_WAIT;
                end
                send_request(op, tid, pri, 1'b0, UNTYPED);
            end
        end
        i_s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        // a signal drains up to a full queue before its result shows
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("priority_event_wait_queue_unit verification clean");
        end else begin
            $display("priority_event_wait_queue_unit verification failed");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #4_000_000;
        $display("priority_event_wait_queue_unit verification failed");
        $finish;
    end

endmodule

>>> priority_event_wait_queue_unit.f
design/pewq_pkg.sv
design/pewq_cell.sv
design/priority_event_wait_queue_unit.sv
verif/priority_event_wait_queue_unit_tb.sv
